@@ rtl/lrul_pkg.sv @@
// Package for the LRU slot pool: command and status codes, default sizes.
// No dependencies; imported by the top level of the slot pool.
package lrul_pkg;

    // Default pool geometry
    localparam int SLOTS_DEF        = 64;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Request commands
    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_SET   = 2'd1,
        CMD_TOUCH = 2'd2,
        CMD_EVICT = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_EMPTY   = 2'd2
    } status_t;

endpackage

@@ rtl/lrul_link_mem.sv @@
// Link memory of the LRU slot pool: next and prev link of every slot.
// One registered read port, one write port with a write enable per link field.
module lrul_link_mem #(
    parameter int SLOTS = 64,
    parameter int AW    = $clog2(SLOTS),
    parameter int LW    = $clog2(SLOTS + 1)
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [LW-1:0] rd_next,
    output logic [LW-1:0] rd_prev,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_next_en,
    input  logic          wr_prev_en,
    input  logic [LW-1:0] wr_next,
    input  logic [LW-1:0] wr_prev
);

    logic [LW-1:0] next_mem [SLOTS];
    logic [LW-1:0] prev_mem [SLOTS];

    // Write each link field on its own enable
    always_ff @(posedge clk)
    begin
        if (wr_next_en)
        begin
            next_mem[wr_addr] <= wr_next;
        end
        if (wr_prev_en)
        begin
            prev_mem[wr_addr] <= wr_prev;
        end
    end

    // Register read data, hold it between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_next <= next_mem[rd_addr];
            rd_prev <= prev_mem[rd_addr];
        end
    end

endmodule

@@ rtl/lrul_pay_mem.sv @@
// Payload memory of the LRU slot pool: one payload word per slot.
// One registered read port and one write port; no dependencies.
module lrul_pay_mem #(
    parameter int SLOTS        = 64,
    parameter int PAYLOAD_BITS = 32,
    parameter int AW           = $clog2(SLOTS)
) (
    input  logic                    clk,
    input  logic                    rd_en,
    input  logic [AW-1:0]           rd_addr,
    output logic [PAYLOAD_BITS-1:0] rd_data,
    input  logic                    wr_en,
    input  logic [AW-1:0]           wr_addr,
    input  logic [PAYLOAD_BITS-1:0] wr_data
);

    logic [PAYLOAD_BITS-1:0] pay_mem [SLOTS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pay_mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= pay_mem[rd_addr];
        end
    end

endmodule

@@ rtl/lru_list_slot_pool_core.sv @@
// Top level of the LRU slot pool: request sequencer, pointer registers, result register.
// Uses lrul_pkg, lrul_link_mem and lrul_pay_mem.

// A pool of SLOTS slots kept on a free list and a doubly linked recency list, with
// commands allocate, set payload, touch (move to top) and evict (remove least recent).
// After reset the block sweeps its memories and accepts no request until the sweep is
// done. Each request then runs alone through the accept, link memory read and decide
// states, then does its link writes one after another, since the link memory has a single
// write port. Set payload and failed commands do no link write; allocate does one,
// evict two and touch up to four (a middle member needs four link writes). A result
// waiting in the output register stalls the next request in its decide cycle.
module lru_list_slot_pool_core
    import lrul_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
    parameter int AW           = $clog2(SLOTS)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              command,
    input  logic [AW-1:0]           slot_index,
    input  logic [PAYLOAD_BITS-1:0] payload_in,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              status,
    output logic [AW-1:0]           slot_out,
    output logic [PAYLOAD_BITS-1:0] payload_out
);

    localparam int            LW  = $clog2(SLOTS + 1);
    localparam logic [LW-1:0] NIL = LW'(SLOTS);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_READ   = 5'b00100,
        S_DECIDE = 5'b01000,
        S_WRITE  = 5'b10000
    } state_t;

    // One planned link write
    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        logic          wn;
        logic          wp;
        logic [LW-1:0] nv;
        logic [LW-1:0] pv;
    } wr_op_t;

    function automatic logic is_slot(input logic [LW-1:0] x);
        return x < NIL;
    endfunction

    state_t                  state_reg, state_next;
    logic [AW-1:0]           clr_cnt_reg, clr_cnt_next;
    cmd_t                    cmd_reg;
    logic [AW-1:0]           slot_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [LW-1:0]           free_head_reg, free_head_next;
    logic [LW-1:0]           top_reg, top_next;
    logic [LW-1:0]           last_reg, last_next;
    wr_op_t                  op_reg [4];
    wr_op_t                  op_next [4];
    logic [2:0]              cnt_reg, cnt_next;
    logic [1:0]              wr_idx_reg, wr_idx_next;
    logic                    out_valid_reg, out_valid_next;
    status_t                 status_reg;
    logic [AW-1:0]           slot_out_reg;
    logic [PAYLOAD_BITS-1:0] payload_out_reg;

    logic                    accept;
    logic                    proceed;
    logic                    clr_done;
    logic                    slot_ok;
    logic                    wr_last;
    wr_op_t                  cur_op;

    // Memory port signals
    logic                    lk_rd_en;
    logic [AW-1:0]           lk_rd_addr;
    logic [LW-1:0]           nx;
    logic [LW-1:0]           pv;
    logic [AW-1:0]           lk_wr_addr;
    logic                    lk_wr_next_en;
    logic                    lk_wr_prev_en;
    logic [LW-1:0]           lk_wr_next;
    logic [LW-1:0]           lk_wr_prev;
    logic                    py_rd_en;
    logic [PAYLOAD_BITS-1:0] py_rd_data;
    logic                    py_wr_en;
    logic [AW-1:0]           py_wr_addr;
    logic [PAYLOAD_BITS-1:0] py_wr_data;

    // Decide-cycle results
    status_t                 dec_status;
    logic [AW-1:0]           dec_slot;
    logic [PAYLOAD_BITS-1:0] dec_pay;
    logic [2:0]              dec_cnt;
    wr_op_t                  plan [4];
    logic [LW-1:0]           dec_free_head;
    logic [LW-1:0]           dec_top;
    logic [LW-1:0]           dec_last;
    logic                    dec_pay_we;
    logic [AW-1:0]           dec_pay_addr;
    logic [PAYLOAD_BITS-1:0] dec_pay_data;
    logic [LW-1:0]           s_ext;
    logic                    link_old;
    logic [LW-1:0]           s_prev;

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign proceed     = !out_valid_reg || out_ready;
    assign clr_done    = (clr_cnt_reg == AW'(SLOTS - 1));
    assign s_ext       = LW'(slot_reg);
    assign slot_ok     = is_slot(s_ext);
    assign cur_op      = op_reg[wr_idx_reg];
    assign wr_last     = ((3'(wr_idx_reg) + 3'd1) == cnt_reg);

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign slot_out    = slot_out_reg;
    assign payload_out = payload_out_reg;

    // Link memory read address per command
    always_comb
    begin
        lk_rd_en   = 1'b0;
        lk_rd_addr = slot_reg;
        py_rd_en   = 1'b0;
        unique case (cmd_reg)
            CMD_ALLOC:
            begin
                lk_rd_addr = free_head_reg[AW-1:0];
                lk_rd_en   = (state_reg == S_READ) && is_slot(free_head_reg);
            end
            CMD_SET:
            begin
                lk_rd_en = 1'b0;
            end
            CMD_TOUCH:
            begin
                lk_rd_en = (state_reg == S_READ) && slot_ok;
            end
            CMD_EVICT:
            begin
                lk_rd_addr = last_reg[AW-1:0];
                lk_rd_en   = (state_reg == S_READ) && is_slot(last_reg);
                py_rd_en   = lk_rd_en;
            end
            default:
            begin
                lk_rd_en = 1'b0;
            end
        endcase
    end

    // Plan the request from the links just read
    always_comb
    begin
        dec_status    = ST_OK;
        dec_slot      = '0;
        dec_pay       = '0;
        dec_cnt       = 3'd0;
        plan[0]       = '0;
        plan[1]       = '0;
        plan[2]       = '0;
        plan[3]       = '0;
        dec_free_head = free_head_reg;
        dec_top       = top_reg;
        dec_last      = last_reg;
        dec_pay_we    = 1'b0;
        dec_pay_addr  = slot_reg;
        dec_pay_data  = pay_reg;
        link_old      = is_slot(top_reg) && (top_reg != s_ext);
        s_prev        = link_old ? top_reg : NIL;
        unique case (cmd_reg)
            CMD_ALLOC:
            begin
                if (!is_slot(free_head_reg))
                begin
                    dec_status = ST_NO_FREE;
                end
                else
                begin
                    dec_slot      = free_head_reg[AW-1:0];
                    dec_free_head = nx;
                    plan[0]       = '{en: 1'b1, addr: free_head_reg[AW-1:0], wn: 1'b1,
                                      wp: 1'b1, nv: NIL, pv: NIL};
                    dec_cnt       = 3'd1;
                    dec_pay_we    = 1'b1;
                    dec_pay_addr  = free_head_reg[AW-1:0];
                    dec_pay_data  = '0;
                end
            end
            CMD_SET:
            begin
                dec_pay_we = slot_ok;
            end
            CMD_TOUCH:
            begin
                if (!slot_ok)
                begin
                    dec_cnt = 3'd0;
                end
                else if (!is_slot(nx) && !is_slot(pv))
                begin
                    // Detached slot: insert at the top unless it already is the top
                    if (s_ext != top_reg)
                    begin
                        dec_top = s_ext;
                        if (!is_slot(last_reg))
                        begin
                            dec_last = s_ext;
                        end
                        plan[0] = '{en: 1'b1, addr: slot_reg, wn: 1'b1, wp: 1'b1,
                                    nv: NIL, pv: s_prev};
                        plan[1] = '{en: link_old, addr: top_reg[AW-1:0], wn: 1'b1,
                                    wp: 1'b0, nv: s_ext, pv: NIL};
                        dec_cnt = 3'd2;
                    end
                end
                else if (is_slot(nx) && is_slot(pv))
                begin
                    // Middle member: unlink, then place at the top
                    dec_top = s_ext;
                    plan[0] = '{en: 1'b1, addr: pv[AW-1:0], wn: 1'b1, wp: 1'b0,
                                nv: nx, pv: NIL};
                    plan[1] = '{en: 1'b1, addr: nx[AW-1:0], wn: 1'b0, wp: 1'b1,
                                nv: NIL, pv: pv};
                    plan[2] = '{en: 1'b1, addr: slot_reg, wn: 1'b1, wp: link_old,
                                nv: NIL, pv: top_reg};
                    plan[3] = '{en: link_old, addr: top_reg[AW-1:0], wn: 1'b1,
                                wp: 1'b0, nv: s_ext, pv: NIL};
                    dec_cnt = 3'd4;
                end
                else if ((s_ext == last_reg) && is_slot(nx))
                begin
                    // Last member: its successor becomes last
                    dec_top  = s_ext;
                    dec_last = nx;
                    plan[0]  = '{en: 1'b1, addr: nx[AW-1:0], wn: 1'b0, wp: 1'b1,
                                 nv: NIL, pv: NIL};
                    plan[1]  = '{en: 1'b1, addr: slot_reg, wn: 1'b1, wp: 1'b1,
                                 nv: NIL, pv: s_prev};
                    plan[2]  = '{en: link_old, addr: top_reg[AW-1:0], wn: 1'b1,
                                 wp: 1'b0, nv: s_ext, pv: NIL};
                    dec_cnt  = 3'd3;
                end
                else
                begin
                    dec_cnt = 3'd0;
                end
            end
            CMD_EVICT:
            begin
                if (!is_slot(last_reg))
                begin
                    dec_status = ST_EMPTY;
                end
                else
                begin
                    dec_slot = last_reg[AW-1:0];
                    dec_pay  = py_rd_data;
                    if (is_slot(nx) && (nx != last_reg))
                    begin
                        dec_last = nx;
                        if (top_reg == last_reg)
                        begin
                            dec_top = NIL;
                        end
                    end
                    else
                    begin
                        dec_last = NIL;
                        dec_top  = NIL;
                    end
                    plan[0]       = '{en: is_slot(nx) && (nx != last_reg),
                                      addr: nx[AW-1:0], wn: 1'b0, wp: 1'b1,
                                      nv: NIL, pv: NIL};
                    plan[1]       = '{en: 1'b1, addr: last_reg[AW-1:0], wn: 1'b1,
                                      wp: 1'b1, nv: free_head_reg, pv: NIL};
                    dec_free_head = last_reg;
                    dec_cnt       = 3'd2;
                end
            end
            default:
            begin
                dec_cnt = 3'd0;
            end
        endcase
    end

    // Steer the memory write ports: clearing sweep, decide cycle, link writes
    always_comb
    begin
        lk_wr_addr    = cur_op.addr;
        lk_wr_next_en = 1'b0;
        lk_wr_prev_en = 1'b0;
        lk_wr_next    = cur_op.nv;
        lk_wr_prev    = cur_op.pv;
        py_wr_en      = 1'b0;
        py_wr_addr    = dec_pay_addr;
        py_wr_data    = dec_pay_data;
        priority case (1'b1)
            (state_reg == S_CLEAR):
            begin
                lk_wr_addr    = clr_cnt_reg;
                lk_wr_next_en = 1'b1;
                lk_wr_prev_en = 1'b1;
                lk_wr_next    = LW'(clr_cnt_reg) + LW'(1);
                lk_wr_prev    = NIL;
                py_wr_en      = 1'b1;
                py_wr_addr    = clr_cnt_reg;
                py_wr_data    = '0;
            end
            (state_reg == S_DECIDE):
            begin
                py_wr_en = proceed && dec_pay_we;
            end
            (state_reg == S_WRITE):
            begin
                lk_wr_next_en = cur_op.en && cur_op.wn;
                lk_wr_prev_en = cur_op.en && cur_op.wp;
            end
            default:
            begin
                py_wr_en = 1'b0;
            end
        endcase
    end

    // Sequencer and pointer next state
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        free_head_next = free_head_reg;
        top_next       = top_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        wr_idx_next    = wr_idx_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (proceed)
                begin
                    out_valid_next = 1'b1;
                    free_head_next = dec_free_head;
                    top_next       = dec_top;
                    last_next      = dec_last;
                    op_next        = plan;
                    cnt_next       = dec_cnt;
                    wr_idx_next    = 2'd0;
                    state_next     = (dec_cnt == 3'd0) ? S_IDLE : S_WRITE;
                end
            end
            S_WRITE:
            begin
                wr_idx_next = wr_idx_reg + 2'd1;
                if (wr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            free_head_reg <= '0;
            top_reg       <= NIL;
            last_reg      <= NIL;
            cnt_reg       <= 3'd0;
            wr_idx_reg    <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            free_head_reg <= free_head_next;
            top_reg       <= top_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            wr_idx_reg    <= wr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: request capture, write plan, result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd_t'(command);
            slot_reg <= slot_index;
            pay_reg  <= payload_in;
        end
        op_reg <= op_next;
        if ((state_reg == S_DECIDE) && proceed)
        begin
            status_reg      <= dec_status;
            slot_out_reg    <= dec_slot;
            payload_out_reg <= dec_pay;
        end
    end

    lrul_link_mem #(
        .SLOTS (SLOTS),
        .AW    (AW),
        .LW    (LW)
    ) u_link_mem (
        .clk        (clk),
        .rd_en      (lk_rd_en),
        .rd_addr    (lk_rd_addr),
        .rd_next    (nx),
        .rd_prev    (pv),
        .wr_addr    (lk_wr_addr),
        .wr_next_en (lk_wr_next_en),
        .wr_prev_en (lk_wr_prev_en),
        .wr_next    (lk_wr_next),
        .wr_prev    (lk_wr_prev)
    );

    lrul_pay_mem #(
        .SLOTS        (SLOTS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .AW           (AW)
    ) u_pay_mem (
        .clk     (clk),
        .rd_en   (py_rd_en),
        .rd_addr (lk_rd_addr),
        .rd_data (py_rd_data),
        .wr_en   (py_wr_en),
        .wr_addr (py_wr_addr),
        .wr_data (py_wr_data)
    );

`ifndef SYNTH
    // A waiting result holds steady until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=>
        (out_valid_reg && $stable(status_reg) && $stable(slot_out_reg)
         && $stable(payload_out_reg)))
        else $error("result changed or dropped while waiting");

    // Link writes never run past the planned count
    a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> ((3'(wr_idx_reg) < cnt_reg) && (cnt_reg <= 3'd4)))
        else $error("link write index beyond planned count");

    // A failed command reports no slot and no payload
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_OK)) |->
        ((slot_out_reg == '0) && (payload_out_reg == '0)))
        else $error("failed command returned a slot or payload");
`endif

endmodule
